>>> sv/sha1s_pkg.sv
// Shared types, constants and selector codes for the SHA-1 stream hasher.
// Used by sha1s_core and sha1_stream_hash; depends on nothing.
`default_nettype none

package sha1s_pkg;

  // Input selector codes
  localparam logic [1:0] FUNC_ABSORB      = 2'd0;
  localparam logic [1:0] FUNC_ABSORB_LAST = 2'd1;
  localparam logic [1:0] FUNC_FINISH      = 2'd2;

  localparam int unsigned NUM_WORDS = 5;
  localparam int unsigned NUM_ROUNDS = 80;

  typedef logic [NUM_WORDS-1:0][31:0] hwords_t;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Index 0 holds H0
  localparam hwords_t H_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                32'hefcdab89, 32'h67452301};

  typedef struct packed {
    logic       push;       // shift one byte into the block buffer
    logic [7:0] push_byte;
    logic       start;      // begin compression of the buffered block
    logic       init;       // reload the chaining words
  } core_ctrl_t;

  typedef struct packed {
    logic done;             // chaining words updated this cycle
  } core_stat_t;

endpackage

`default_nettype wire

>>> sv/sha1s_core.sv
// SHA-1 block buffer, message schedule and single round unit.
// One round per cycle through 80 rounds, then the chaining adds.
// Depends on sha1s_pkg.
`default_nettype none

module sha1s_core (
  input  wire                  clk,
  input  wire                  rst,
  input  sha1s_pkg::core_ctrl_t ctrl,
  output sha1s_pkg::core_stat_t stat,
  output sha1s_pkg::hwords_t    h
);

  // 16-word window; word 0 sits at the top bits
  logic [511:0] blk;
  logic [31:0]  a, b, c, d, e;
  logic [6:0]   t;
  logic         running;
  logic         add_pend;

  logic [31:0] w0, w2, w8, w13, w_new;
  logic [31:0] f, k, sum;

  assign w0  = blk[511:480];
  assign w2  = blk[447:416];
  assign w8  = blk[255:224];
  assign w13 = blk[95:64];

  always_comb begin
    logic [31:0] x;
    x = w13 ^ w8 ^ w2 ^ w0;
    w_new = {x[30:0], x[31]};
  end

  always_comb begin
    priority if (t < 7'd20) begin
      f = (b & c) | (~b & d);
      k = sha1s_pkg::K0;
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1s_pkg::K1;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1s_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1s_pkg::K3;
    end
  end

  assign sum = {a[26:0], a[31:27]} + f + e + k + w0;

  assign stat.done = add_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      add_pend <= 1'b0;
      t        <= '0;
      h        <= sha1s_pkg::H_INIT;
    end else begin
      // chaining adds follow the last round
      add_pend <= !ctrl.start && running &&
                  (t == 7'(sha1s_pkg::NUM_ROUNDS - 1));
      if (ctrl.init) begin
        h <= sha1s_pkg::H_INIT;
      end
      if (ctrl.push) begin
        blk <= {blk[503:0], ctrl.push_byte};
      end
      if (ctrl.start) begin
        a       <= h[0];
        b       <= h[1];
        c       <= h[2];
        d       <= h[3];
        e       <= h[4];
        t       <= '0;
        running <= 1'b1;
      end else if (running) begin
        a   <= sum;
        b   <= a;
        c   <= {b[1:0], b[31:2]};
        d   <= c;
        e   <= d;
        blk <= {blk[479:0], w_new};
        t   <= t + 7'd1;
        if (t == 7'(sha1s_pkg::NUM_ROUNDS - 1)) begin
          running <= 1'b0;
        end
      end
      if (add_pend) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/sha1_stream_hash.sv
// SHA-1 stream hasher top level: byte intake, padding sequencer, digest output.
// Depends on sha1s_pkg and sha1s_core.
//
// Usage:
//  Input channel (item_valid/item_ready) carries func and byte_value. func 0
//  absorbs a byte, 1 absorbs a byte and finishes, 2 finishes with no byte,
//  3 is dropped. item_ready is high only while the sequencer is idle.
//  A plain byte leaves the sequencer idle; the byte that fills a 64-byte
//  block keeps it busy for 80 rounds of the round unit plus the chaining adds.
//  A finish runs the padding one byte per cycle through the block buffer
//  (0x80, zeros, 8 length bytes), pausing while a full block is compressed,
//  with one or two compressions before the first digest word.
//  Output channel (digest_valid/digest_ready) delivers five transactions,
//  H0 first, word_index 0..4, last_word set on the fifth. The digest is held
//  while the receiver stalls; no new input is taken until the fifth word
//  is accepted, after which the chaining words and byte count reinitialize.
//  Long-message throughput is set by the one-round-per-cycle compression
//  unit, as no byte is taken while a block is compressed.
//  Reset (rst, synchronous) loads the SHA-1 initial words and clears the
//  byte count.
`default_nettype none

module sha1_stream_hash (
  input  wire         clk,
  input  wire         rst,
  input  wire         item_valid,
  output logic        item_ready,
  input  wire  [1:0]  func,
  input  wire  [7:0]  byte_value,
  output logic        digest_valid,
  input  wire         digest_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_PADZ,
    S_LEN,
    S_COMP,
    S_OUT
  } state_t;

  state_t                state, ret;
  logic [60:0]           count;
  logic [63:0]           len;
  logic [2:0]            oidx;
  logic [5:0]            pos;
  logic                  accept;
  sha1s_pkg::core_ctrl_t ctrl;
  sha1s_pkg::core_stat_t stat;
  sha1s_pkg::hwords_t    h;

  sha1s_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat),
    .h    (h)
  );

  assign pos    = count[5:0];
  assign accept = item_valid && item_ready;

  assign item_ready   = (state == S_IDLE);
  assign digest_valid = (state == S_OUT);
  assign digest_word  = h[oidx];
  assign word_index   = oidx;
  assign last_word    = (oidx == 3'(sha1s_pkg::NUM_WORDS - 1));

  always_comb begin
    ctrl.push      = 1'b0;
    ctrl.push_byte = byte_value;
    ctrl.init      = 1'b0;
    unique case (state)
      S_IDLE:  ctrl.push = accept && (func == sha1s_pkg::FUNC_ABSORB ||
                                      func == sha1s_pkg::FUNC_ABSORB_LAST);
      S_PAD80: begin
        ctrl.push      = 1'b1;
        ctrl.push_byte = sha1s_pkg::PAD_BYTE;
      end
      S_PADZ: begin
        ctrl.push      = (pos != 6'd56);
        ctrl.push_byte = 8'h00;
      end
      S_LEN: begin
        ctrl.push      = 1'b1;
        ctrl.push_byte = len[63:56];
      end
      S_OUT:   ctrl.init = digest_ready && last_word;
      default: ;
    endcase
    // the byte that fills the block kicks off compression
    ctrl.start = ctrl.push && (pos == 6'd63);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      count <= '0;
      oidx  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (func)
              sha1s_pkg::FUNC_ABSORB: begin
                count <= count + 61'd1;
                if (pos == 6'd63) begin
                  state <= S_COMP;
                  ret   <= S_IDLE;
                end
              end
              sha1s_pkg::FUNC_ABSORB_LAST: begin
                count <= count + 61'd1;
                ret   <= S_PAD80;
                state <= (pos == 6'd63) ? S_COMP : S_PAD80;
              end
              sha1s_pkg::FUNC_FINISH: state <= S_PAD80;
              default: ;
            endcase
          end
        end
        S_PAD80: begin
          len   <= {count, 3'b000};
          count <= count + 61'd1;
          ret   <= S_PADZ;
          state <= (pos == 6'd63) ? S_COMP : S_PADZ;
        end
        S_PADZ: begin
          if (pos == 6'd56) begin
            state <= S_LEN;
          end else begin
            count <= count + 61'd1;
            if (pos == 6'd63) begin
              state <= S_COMP;
              ret   <= S_PADZ;
            end
          end
        end
        S_LEN: begin
          count <= count + 61'd1;
          len   <= {len[55:0], 8'h00};
          if (pos == 6'd63) begin
            state <= S_COMP;
            ret   <= S_OUT;
          end
        end
        S_COMP: begin
          if (stat.done) begin
            state <= ret;
          end
        end
        S_OUT: begin
          if (digest_ready) begin
            if (last_word) begin
              oidx  <= '0;
              count <= '0;
              state <= S_IDLE;
            end else begin
              oidx <= oidx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/sha1_stream_hash_test.sv
// Self-checking testbench for sha1_stream_hash: byte-stream SHA-1 digests checked
// word by word against a built-in predictor. Depends on sha1s_pkg and the RTL only.
`timescale 1ns / 100ps

module sha1_stream_hash_test;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 180;
  localparam int unsigned HOLDOFF_CYCLES = 800;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned LIMIT_CYCLES = 200000;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_entry_t;

  class digest_scoreboard;
    sha1s_pkg::hwords_t chain;
    logic [7:0]    block_bytes [64];
    logic [60:0]   byte_total;
    digest_entry_t digest_words_due [$];
    int unsigned   mismatches;
    int unsigned   words_checked;
    int unsigned   messages_hashed;
    int unsigned   bytes_hashed;

    function new();
      restart_message();
    endfunction

    function void restart_message();
      chain = sha1s_pkg::H_INIT;
      byte_total = '0;
      foreach (block_bytes[i]) block_bytes[i] = 8'h00;
    endfunction

    function void compress_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, sum;
      for (int t = 0; t < 16; t++)
        w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                block_bytes[4*t+3]};
      for (int t = 16; t < 80; t++) begin
        sum = w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16];
        w[t] = {sum[30:0], sum[31]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int t = 0; t < 80; t++) begin
        if (t < 20) begin
          f = (b & c) | (~b & d);
          k = sha1s_pkg::K0;
        end else if (t < 40) begin
          f = b ^ c ^ d;
          k = sha1s_pkg::K1;
        end else if (t < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = sha1s_pkg::K2;
        end else begin
          f = b ^ c ^ d;
          k = sha1s_pkg::K3;
        end
        sum = {a[26:0], a[31:27]} + f + e + k + w[t];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = sum;
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
      chain[4] = chain[4] + e;
    endfunction

    // Called once per accepted input transaction.
    function void note_input(logic [1:0] sel, logic [7:0] data);
      int          pos;
      logic [63:0] bit_len;
      if (sel == FUNC_UNUSED) return;
      if (sel != sha1s_pkg::FUNC_FINISH) begin
        pos = int'(byte_total[5:0]);
        block_bytes[pos] = data;
        byte_total = byte_total + 61'd1;  // wraps at 2^61
        bytes_hashed++;
        if (pos == 63) compress_block();
      end
      if (sel == sha1s_pkg::FUNC_ABSORB) return;

      bit_len = {byte_total, 3'b000};
      pos = int'(byte_total[5:0]);
      block_bytes[pos] = sha1s_pkg::PAD_BYTE;
      pos++;
      // no room left for the length: pad out this block and start another
      if (pos > 56) begin
        for (int i = pos; i < 64; i++) block_bytes[i] = 8'h00;
        compress_block();
        pos = 0;
      end
      for (int i = pos; i < 56; i++) block_bytes[i] = 8'h00;
      for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < sha1s_pkg::NUM_WORDS; i++)
        digest_words_due.push_back('{chain[i], 3'(i),
                                     (i == sha1s_pkg::NUM_WORDS - 1)});
      messages_hashed++;
      restart_message();
    endfunction

    function void check_result(logic [31:0] word, logic [2:0] idx, logic last);
      digest_entry_t due;
      if (digest_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h index %0d last %0b", word, idx, last);
        return;
      end
      due = digest_words_due.pop_front();
      words_checked++;
      if (due.word !== word || due.idx !== idx || due.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("digest mismatch: expected word %h index %0d last %0b, got %h %0d %0b",
                   due.word, due.idx, due.last, word, idx, last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [1:0]  func = sha1s_pkg::FUNC_ABSORB;
  logic [7:0]  byte_value = 8'h00;
  logic        digest_valid;
  logic        digest_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  digest_scoreboard board = new();
  int unsigned      items_sent;
  int unsigned      ignored_items;
  int unsigned      burst_left;
  int unsigned      holdoff_asks;
  int unsigned      holdoff_served;
  int unsigned      holdoff_left;
  int unsigned      rx_cycle;
  int unsigned      cycle_count;

  sha1_stream_hash dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .func         (func),
    .byte_value   (byte_value),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: check each accepted word, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst && digest_valid && digest_ready)
      board.check_result(digest_word, word_index, last_word);
    rx_cycle++;
    if (holdoff_asks != holdoff_served) begin
      holdoff_served++;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      digest_ready <= 1'b0;
    end else begin
      case (rx_cycle[8:7])
        2'd0: digest_ready <= 1'b1;
        2'd1: digest_ready <= 1'($urandom_range(0, 1));
        2'd2: digest_ready <= (rx_cycle[1:0] == 2'd0);
        default: digest_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  task automatic send_item(input logic [1:0] sel, input logic [7:0] data);
    item_valid <= 1'b1;
    func <= sel;
    byte_value <= data;
    do @(posedge clk); while (!item_ready);
    board.note_input(sel, data);
  endtask

  // Sender bursts: random burst length, random idle gap between bursts.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_message(input int unsigned len);
    bit         close_on_byte;
    logic [7:0] data;
    close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned n = 0; n < len; n++) begin
      pace_sender();
      if ($urandom_range(0, 11) == 0) begin
        send_item(FUNC_UNUSED, 8'($urandom));
        ignored_items++;
      end
      data = 8'($urandom);
      send_item((close_on_byte && n == len - 1) ? sha1s_pkg::FUNC_ABSORB_LAST
                                                : sha1s_pkg::FUNC_ABSORB, data);
      items_sent++;
    end
    if (!close_on_byte) begin
      pace_sender();
      send_item(sha1s_pkg::FUNC_FINISH, 8'($urandom));
      items_sent++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty messages, ignored selector, extreme bytes, "abc"
    send_item(sha1s_pkg::FUNC_FINISH, 8'hff);
    send_item(FUNC_UNUSED, 8'hff);
    send_item(sha1s_pkg::FUNC_ABSORB_LAST, 8'h00);
    send_item(sha1s_pkg::FUNC_ABSORB_LAST, 8'hff);
    send_item(sha1s_pkg::FUNC_ABSORB, 8'h61);
    send_item(sha1s_pkg::FUNC_ABSORB, 8'h62);
    send_item(FUNC_UNUSED, 8'h00);
    send_item(sha1s_pkg::FUNC_ABSORB_LAST, 8'h63);
    send_item(sha1s_pkg::FUNC_ABSORB, 8'hff);
    send_item(sha1s_pkg::FUNC_ABSORB, 8'h00);
    send_item(sha1s_pkg::FUNC_ABSORB, 8'h80);
    send_item(sha1s_pkg::FUNC_FINISH, 8'h00);
    send_item(sha1s_pkg::FUNC_FINISH, 8'h55);
    send_item(sha1s_pkg::FUNC_FINISH, 8'haa);
    ignored_items = 2;

    // long receiver hold-off over the first random message, whose 56 to 63 bytes force a second padding block
    holdoff_asks++;
    send_message($urandom_range(56, 63));
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent > RANDOM_ITEMS / 2 && holdoff_asks == 1) holdoff_asks++;
      send_message(($urandom_range(0, 4) == 0) ? $urandom_range(52, 66)
                                                : $urandom_range(0, 16));
    end
    item_valid <= 1'b0;

    while (board.digest_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages (%0d bytes), %0d selector-3 items ignored.",
             board.messages_hashed, board.bytes_hashed, ignored_items);
    $display("Checked %0d digest words, %0d mismatches.",
             board.words_checked, board.mismatches);
    if (board.mismatches == 0 && board.digest_words_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sha1_stream_hash.f
sv/sha1s_pkg.sv
sv/sha1s_core.sv
sv/sha1_stream_hash.sv
tb/sha1_stream_hash_test.sv
